// ===== rtl/core/lpr_pkg.sv =====
package lpr_pkg;

   localparam int CFG_W       = 7;
   localparam int HIT_COUNT_W = 32;

   localparam logic [CFG_W-1:0]       CFG_RESET = 7'd64;
   localparam logic [HIT_COUNT_W-1:0] HIT_MAX   = {HIT_COUNT_W{1'b1}};

   typedef struct packed {
      logic load;
      logic compare;
      logic commit;
   } lpr_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } lpr_status_type;

endpackage

// ===== rtl/core/lpr_req_if.sv =====
interface lpr_req_if #(
   parameter int PAGE_BITS = 10
);
   logic                 valid;
   logic                 ready;
   logic [PAGE_BITS-1:0] page;
   logic                 final_reference;

   modport source (output valid, output page, output final_reference, input ready);
   modport sink   (input valid, input page, input final_reference, output ready);
endinterface

// ===== rtl/core/lpr_rsp_if.sv =====
interface lpr_rsp_if #(
   parameter int PAGE_BITS = 10
);
   import lpr_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic                   evicted;
   logic [PAGE_BITS-1:0]   evicted_page;
   logic [HIT_COUNT_W-1:0] hit_count;

   modport source (output valid, output hit, output evicted, output evicted_page,
                   output hit_count, input ready);
   modport sink   (input valid, input hit, input evicted, input evicted_page,
                   input hit_count, output ready);
endinterface

// ===== rtl/core/lpr_controller.sv =====
module lpr_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lpr_pkg::lpr_status_type status,
   output lpr_pkg::lpr_cmd_type    cmd
);
   import lpr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.compare = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.compare = 1'b1;
            state_in    = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the response register can take the result
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/lpr_datapath.sv =====
module lpr_datapath #(
   parameter int MAX_FRAMES = 64,
   parameter int PAGE_BITS  = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [PAGE_BITS-1:0]              req_page,
   input  logic                              req_final_reference,
   input  logic                              csr_wr_en,
   input  logic [lpr_pkg::CFG_W-1:0]         csr_wr_data,
   input  lpr_pkg::lpr_cmd_type              cmd,
   output lpr_pkg::lpr_status_type           status,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic                              rsp_evicted,
   output logic [PAGE_BITS-1:0]              rsp_evicted_page,
   output logic [lpr_pkg::HIT_COUNT_W-1:0]   rsp_hit_count
);
   import lpr_pkg::*;

   localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int FILL_W = $clog2(MAX_FRAMES + 1);
   localparam int LIM_W  = CFG_W + FILL_W;
   localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(MAX_FRAMES);

   logic [CFG_W-1:0]       frames_in_use_ff;
   logic [PAGE_BITS-1:0]   page_ff;
   logic                   final_ff;
   logic                   hit_ff;
   logic                   room_ff;
   logic [IDX_W-1:0]       bound_ff;
   logic [PAGE_BITS-1:0]   stack_ff [MAX_FRAMES];
   logic [PAGE_BITS-1:0]   stack_in [MAX_FRAMES];
   logic [FILL_W-1:0]      filled_ff;
   logic [FILL_W-1:0]      filled_in;
   logic [HIT_COUNT_W-1:0] hits_ff;
   logic [HIT_COUNT_W-1:0] hits_in;
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic                   rsp_evicted_ff;
   logic [PAGE_BITS-1:0]   rsp_evicted_page_ff;
   logic [HIT_COUNT_W-1:0] rsp_hit_count_ff;

   logic [MAX_FRAMES-1:0]  match;
   logic [IDX_W-1:0]       found_idx;
   logic                   any_match;
   logic [LIM_W-1:0]       cfg_ext;
   logic [LIM_W-1:0]       limit;
   logic                   room;
   logic [IDX_W-1:0]       bound_in;
   logic                   evict;
   logic [PAGE_BITS-1:0]   lru_page;

   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      found_idx = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         match[i] = (FILL_W'(i) < filled_ff) && (stack_ff[i] == page_ff);
         if (match[i]) begin
            found_idx = found_idx | IDX_W'(i);
         end
      end
      any_match = |match;
   end

   always_comb begin
      cfg_ext = LIM_W'(frames_in_use_ff);
      if (cfg_ext == '0) begin
         limit = LIM_W'(1);
      end else if (cfg_ext > LIM_MAX) begin
         limit = LIM_MAX;
      end else begin
         limit = cfg_ext;
      end
      room = LIM_W'(filled_ff) < limit;
      if (any_match) begin
         bound_in = found_idx;
      end else if (room) begin
         bound_in = IDX_W'(filled_ff);
      end else begin
         bound_in = IDX_W'(filled_ff - FILL_W'(1));
      end
   end

   always_comb begin
      evict    = !hit_ff && !room_ff;
      lru_page = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         if (IDX_W'(i) == bound_ff) begin
            lru_page = lru_page | stack_ff[i];
         end
      end
      stack_in[0] = page_ff;
      for (int i = 1; i < MAX_FRAMES; i++) begin
         stack_in[i] = (IDX_W'(i) <= bound_ff) ? stack_ff[i-1] : stack_ff[i];
      end
      if (hit_ff && hits_ff != HIT_MAX) begin
         hits_in = hits_ff + HIT_COUNT_W'(1);
      end else begin
         hits_in = hits_ff;
      end
      if (!hit_ff && room_ff) begin
         filled_in = filled_ff + FILL_W'(1);
      end else begin
         filled_in = filled_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff  <= req_page;
         final_ff <= req_final_reference;
      end
      if (cmd.compare) begin
         hit_ff   <= any_match;
         room_ff  <= room;
         bound_ff <= bound_in;
      end
      if (cmd.commit) begin
         for (int i = 0; i < MAX_FRAMES; i++) begin
            stack_ff[i] <= stack_in[i];
         end
         rsp_hit_ff          <= hit_ff;
         rsp_evicted_ff      <= evict;
         rsp_evicted_page_ff <= evict ? lru_page : '0;
         rsp_hit_count_ff    <= hits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= CFG_RESET;
         filled_ff        <= '0;
         hits_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            frames_in_use_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            // drop the run state after a final request
            filled_ff    <= final_ff ? '0 : filled_in;
            hits_ff      <= final_ff ? '0 : hits_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;
   assign rsp_hit_count    = rsp_hit_count_ff;

endmodule

// ===== rtl/core/lru_page_replacement_top.sv =====
// LRU page replacement.
// req_bus carries one page reference per request (page, final_reference);
// rsp_bus returns one result per request: hit, evicted, evicted_page and the
// saturating hit count of the current run. Both use valid/ready handshakes.
// csr_wr_en/csr_wr_data write frames_in_use (0 acts as 1, values above
// MAX_FRAMES act as MAX_FRAMES); write it only while the block is idle.
// The controller steps each request through load, compare across all recency
// cells, then shift and commit; it takes no new request until the last one is
// committed to the response register.
// The response register lets the next request enter while a result waits.
// When the receiver stalls, the commit step holds until the response
// register is free; no result is lost or repeated.
// Reset empties the recency store, clears the hit count and sets
// frames_in_use to 64. A final request does the same for the run state
// (not the register) after its result is formed.
module lru_page_replacement_top #(
   parameter int MAX_FRAMES = 64,
   parameter int PAGE_BITS  = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   lpr_req_if.sink                   req_bus,
   lpr_rsp_if.source                 rsp_bus,
   input  logic                      csr_wr_en,
   input  logic [lpr_pkg::CFG_W-1:0] csr_wr_data
);
   import lpr_pkg::*;

   lpr_cmd_type    cmd;
   lpr_status_type status;
   logic           req_ready;

   assign req_bus.ready = req_ready;

   lpr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lpr_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_page            (req_bus.page),
      .req_final_reference (req_bus.final_reference),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .cmd                 (cmd),
      .status              (status),
      .rsp_ready           (rsp_bus.ready),
      .rsp_valid           (rsp_bus.valid),
      .rsp_hit             (rsp_bus.hit),
      .rsp_evicted         (rsp_bus.evicted),
      .rsp_evicted_page    (rsp_bus.evicted_page),
      .rsp_hit_count       (rsp_bus.hit_count)
   );

endmodule
